@@ rtl/sha_pkg.sv @@
// sha_pkg: shared types, round constants, initial hash values and sigma functions
// for the streaming SHA-256 hasher; no dependencies
`default_nettype none

package sha_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 61;
  localparam int unsigned Rounds  = 64;

  // control from the sequencer to the round unit
  typedef struct packed {
    logic       load;      // shift chain read data into working vars
    logic       rot;       // rotate working vars during the final add
    logic       step;      // one compression round
    logic       wsel_mem;  // round word comes from the block memory
    logic [5:0] ridx;      // round number
  } round_ctl_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    ror32 = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] iv_const(input logic [2:0] idx);
    case (idx)
      3'd0:    iv_const = 32'h6a09e667;
      3'd1:    iv_const = 32'hbb67ae85;
      3'd2:    iv_const = 32'h3c6ef372;
      3'd3:    iv_const = 32'ha54ff53a;
      3'd4:    iv_const = 32'h510e527f;
      3'd5:    iv_const = 32'h9b05688c;
      3'd6:    iv_const = 32'h1f83d9ab;
      default: iv_const = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] k_const(input logic [5:0] idx);
    case (idx)
      6'd0:  k_const = 32'h428a2f98;  6'd1:  k_const = 32'h71374491;
      6'd2:  k_const = 32'hb5c0fbcf;  6'd3:  k_const = 32'he9b5dba5;
      6'd4:  k_const = 32'h3956c25b;  6'd5:  k_const = 32'h59f111f1;
      6'd6:  k_const = 32'h923f82a4;  6'd7:  k_const = 32'hab1c5ed5;
      6'd8:  k_const = 32'hd807aa98;  6'd9:  k_const = 32'h12835b01;
      6'd10: k_const = 32'h243185be;  6'd11: k_const = 32'h550c7dc3;
      6'd12: k_const = 32'h72be5d74;  6'd13: k_const = 32'h80deb1fe;
      6'd14: k_const = 32'h9bdc06a7;  6'd15: k_const = 32'hc19bf174;
      6'd16: k_const = 32'he49b69c1;  6'd17: k_const = 32'hefbe4786;
      6'd18: k_const = 32'h0fc19dc6;  6'd19: k_const = 32'h240ca1cc;
      6'd20: k_const = 32'h2de92c6f;  6'd21: k_const = 32'h4a7484aa;
      6'd22: k_const = 32'h5cb0a9dc;  6'd23: k_const = 32'h76f988da;
      6'd24: k_const = 32'h983e5152;  6'd25: k_const = 32'ha831c66d;
      6'd26: k_const = 32'hb00327c8;  6'd27: k_const = 32'hbf597fc7;
      6'd28: k_const = 32'hc6e00bf3;  6'd29: k_const = 32'hd5a79147;
      6'd30: k_const = 32'h06ca6351;  6'd31: k_const = 32'h14292967;
      6'd32: k_const = 32'h27b70a85;  6'd33: k_const = 32'h2e1b2138;
      6'd34: k_const = 32'h4d2c6dfc;  6'd35: k_const = 32'h53380d13;
      6'd36: k_const = 32'h650a7354;  6'd37: k_const = 32'h766a0abb;
      6'd38: k_const = 32'h81c2c92e;  6'd39: k_const = 32'h92722c85;
      6'd40: k_const = 32'ha2bfe8a1;  6'd41: k_const = 32'ha81a664b;
      6'd42: k_const = 32'hc24b8b70;  6'd43: k_const = 32'hc76c51a3;
      6'd44: k_const = 32'hd192e819;  6'd45: k_const = 32'hd6990624;
      6'd46: k_const = 32'hf40e3585;  6'd47: k_const = 32'h106aa070;
      6'd48: k_const = 32'h19a4c116;  6'd49: k_const = 32'h1e376c08;
      6'd50: k_const = 32'h2748774c;  6'd51: k_const = 32'h34b0bcb5;
      6'd52: k_const = 32'h391c0cb3;  6'd53: k_const = 32'h4ed8aa4a;
      6'd54: k_const = 32'h5b9cca4f;  6'd55: k_const = 32'h682e6ff3;
      6'd56: k_const = 32'h748f82ee;  6'd57: k_const = 32'h78a5636f;
      6'd58: k_const = 32'h84c87814;  6'd59: k_const = 32'h8cc70208;
      6'd60: k_const = 32'h90befffa;  6'd61: k_const = 32'ha4506ceb;
      6'd62: k_const = 32'hbef9a3f7;  default: k_const = 32'hc67178f2;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ rtl/sha_blk_mem.sv @@
// sha_blk_mem: 16 x 32-bit block buffer memory, one write and one registered read port
// depends on sha_pkg
`default_nettype none

module sha_blk_mem (
  input  wire  logic                       clk,
  input  wire  logic                       we,
  input  wire  logic [3:0]                 waddr,
  input  wire  logic [sha_pkg::WordW-1:0]  wdata,
  input  wire  logic                       re,
  input  wire  logic [3:0]                 raddr,
  output logic       [sha_pkg::WordW-1:0]  rdata
);
  import sha_pkg::*;

  logic [WordW-1:0] mem [0:15];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sha_chain_mem.sv @@
// sha_chain_mem: 8 x 32-bit chaining value memory with per-entry valid bits;
// an entry not written since reset or clear reads as the initial hash value; depends on sha_pkg
`default_nettype none

module sha_chain_mem (
  input  wire  logic                       clk,
  input  wire  logic                       rst,
  input  wire  logic                       clr,
  input  wire  logic                       we,
  input  wire  logic [2:0]                 waddr,
  input  wire  logic [sha_pkg::WordW-1:0]  wdata,
  input  wire  logic                       re,
  input  wire  logic [2:0]                 raddr,
  output logic       [sha_pkg::WordW-1:0]  rdata
);
  import sha_pkg::*;

  logic [WordW-1:0] mem [0:7];
  logic [7:0]       vld;
  logic [WordW-1:0] rd_mem;
  logic             rd_vld;
  logic [2:0]       rd_addr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_mem  <= mem[raddr];
      rd_vld  <= vld[raddr];
      rd_addr <= raddr;
    end
  end

  assign rdata = rd_vld ? rd_mem : iv_const(rd_addr);

`ifndef SYNTH
  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (we && !clr) |=> vld[$past(waddr)])
    else $error("chain entry not valid after write");
`endif

endmodule

`default_nettype wire

@@ rtl/sha_round.sv @@
// sha_round: working variables, rolling message schedule and one SHA-256 round per cycle
// depends on sha_pkg (round_ctl_t, round constants, sigma functions)
`default_nettype none

module sha_round (
  input  wire  logic                       clk,
  input  wire  sha_pkg::round_ctl_t        ctl,
  input  wire  logic [sha_pkg::WordW-1:0]  chain_rd,
  input  wire  logic [sha_pkg::WordW-1:0]  blk_rd,
  output logic       [sha_pkg::WordW-1:0]  a_out
);
  import sha_pkg::*;

  logic [WordW-1:0] wv [0:7];
  // sched[14] is the newest schedule word, sched[0] the oldest
  logic [WordW-1:0] sched [0:14];
  logic [WordW-1:0] w_reg;
  logic [WordW-1:0] wsrc;
  logic [WordW-1:0] t1;
  logic [WordW-1:0] t2;
  logic [WordW-1:0] shift_in;

  assign wsrc = ctl.wsel_mem ? blk_rd : w_reg;
  assign t1 = wv[7] + big_sig1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
            + k_const(ctl.ridx) + wsrc;
  assign t2 = big_sig0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  assign shift_in = ctl.load ? chain_rd : wv[0];
  assign a_out = wv[0];

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      wv[0] <= t1 + t2;
      wv[1] <= wv[0];
      wv[2] <= wv[1];
      wv[3] <= wv[2];
      wv[4] <= wv[3] + t1;
      wv[5] <= wv[4];
      wv[6] <= wv[5];
      wv[7] <= wv[6];
    end else if (ctl.load || ctl.rot) begin
      for (int j = 0; j < 7; j++) begin
        wv[j] <= wv[j+1];
      end
      wv[7] <= shift_in;
    end
  end

  // the schedule word for the coming round is computed ahead and registered in w_reg
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      for (int j = 0; j < 14; j++) begin
        sched[j] <= sched[j+1];
      end
      sched[14] <= wsrc;
      w_reg <= small_sig1(sched[14]) + sched[9] + small_sig0(sched[1]) + sched[0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sha256_stream_hasher_core.sv @@
// sha256_stream_hasher_core: top level, byte intake, padding sequencer and digest output
// depends on sha_pkg, sha_blk_mem, sha_chain_mem, sha_round
`default_nettype none

// SHA-256 over a byte stream. Each input item carries at most one message byte and
// an end mark. A byte item is taken while the core is idle; the byte that fills a
// 64-byte block starts a compression (reading the chaining value from its memory,
// 64 rounds at one round per cycle, then adding and writing the chaining value
// back), during which no item is taken. An end mark starts padding, which writes
// the rest of the block memory one word per cycle, followed by one or two
// compressions. The digest then leaves as eight items, word 0 first, each read
// from the chaining value memory and loaded into the output register once that
// register is free. A new message can start while the last digest word still
// waits in the output register.
module sha256_stream_hasher_core (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        in_valid,
  output logic              in_stall,
  input  wire  logic [7:0]  msg_byte,
  input  wire  logic        has_byte,
  input  wire  logic        end_of_message,
  output logic              out_valid,
  input  wire  logic        out_stall,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index,
  output logic              digest_done
);
  import sha_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_ORD   = 3'd5;
  localparam logic [2:0] S_OWT   = 3'd6;

  // what follows a compression
  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_PAD  = 2'd1;
  localparam logic [1:0] P_PAD2 = 2'd2;
  localparam logic [1:0] P_OUT  = 2'd3;

  logic [2:0]        state;
  logic [6:0]        cnt;
  logic [CountW-1:0] count;
  logic [23:0]       acc;
  logic [1:0]        post;
  logic              pad2;
  logic [3:0]        pad_addr;
  logic [2:0]        oidx;

  logic              in_acc;
  logic [5:0]        pos;
  logic [5:0]        pos_inc;
  logic [63:0]       bit_len;
  logic [WordW-1:0]  pad_word;
  logic              out_load;
  logic              fin;
  logic [6:0]        cnt_dec;

  logic              blk_we;
  logic [3:0]        blk_waddr;
  logic [WordW-1:0]  blk_wdata;
  logic              blk_re;
  logic [3:0]        blk_raddr;
  logic [WordW-1:0]  blk_rd;

  logic              c_we;
  logic              c_re;
  logic [2:0]        c_raddr;
  logic [WordW-1:0]  c_rd;
  logic [WordW-1:0]  a_cur;

  round_ctl_t        rctl;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pos      = count[5:0];
  assign pos_inc  = pos + 6'd1;
  assign bit_len  = {count, 3'b000};
  assign cnt_dec  = cnt - 7'd1;
  assign out_load = (state == S_OWT) && (!out_valid || !out_stall);
  assign fin      = out_load && (oidx == 3'd7);

  // padding word: 0x80 after the last message byte, zeros, bit length in words 14 and 15 of the last block
  always_comb begin
    pad_word = '0;
    if (!pad2 && (pad_addr == pos[5:2])) begin
      case (pos[1:0])
        2'd0:    pad_word = 32'h8000_0000;
        2'd1:    pad_word = {acc[7:0], 8'h80, 16'h0000};
        2'd2:    pad_word = {acc[15:0], 8'h80, 8'h00};
        default: pad_word = {acc[23:0], 8'h80};
      endcase
    end else if (pad2 || (pos < 6'd56)) begin
      if (pad_addr == 4'd14) begin
        pad_word = bit_len[63:32];
      end else if (pad_addr == 4'd15) begin
        pad_word = bit_len[31:0];
      end
    end
  end

  always_comb begin
    blk_we    = 1'b0;
    blk_waddr = pad_addr;
    blk_wdata = pad_word;
    if (in_acc && has_byte && (pos[1:0] == 2'd3)) begin
      blk_we    = 1'b1;
      blk_waddr = pos[5:2];
      blk_wdata = {acc, msg_byte};
    end else if (state == S_PAD) begin
      blk_we    = 1'b1;
    end
  end

  assign blk_re    = ((state == S_LOAD) && (cnt == 7'd8)) ||
                     ((state == S_ROUND) && (cnt < 7'd16));
  assign blk_raddr = (state == S_ROUND) ? cnt[3:0] : 4'd0;

  always_comb begin
    c_re    = 1'b0;
    c_raddr = cnt[2:0];
    if (((state == S_LOAD) || (state == S_ADD)) && (cnt < 7'd8)) begin
      c_re = 1'b1;
    end else if (state == S_ORD) begin
      c_re    = 1'b1;
      c_raddr = oidx;
    end
  end

  assign c_we = (state == S_ADD) && (cnt != 7'd0);

  always_comb begin
    rctl.load     = (state == S_LOAD) && (cnt != 7'd0);
    rctl.rot      = c_we;
    rctl.step     = (state == S_ROUND);
    rctl.wsel_mem = (cnt <= 7'd16);
    rctl.ridx     = cnt_dec[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      count    <= '0;
      post     <= P_IDLE;
      pad2     <= 1'b0;
      pad_addr <= '0;
      oidx     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (has_byte) begin
              count <= count + 61'd1;
              if (pos == 6'd63) begin
                state <= S_LOAD;
                cnt   <= '0;
                post  <= end_of_message ? P_PAD : P_IDLE;
              end else if (end_of_message) begin
                state    <= S_PAD;
                pad_addr <= pos_inc[5:2];
                pad2     <= 1'b0;
              end
            end else if (end_of_message) begin
              state    <= S_PAD;
              pad_addr <= pos[5:2];
              pad2     <= 1'b0;
            end
          end
        end
        S_PAD: begin
          pad_addr <= pad_addr + 4'd1;
          if (pad_addr == 4'd15) begin
            state <= S_LOAD;
            cnt   <= '0;
            post  <= (!pad2 && (pos >= 6'd56)) ? P_PAD2 : P_OUT;
          end
        end
        S_LOAD: begin
          if (cnt == 7'd8) begin
            state <= S_ROUND;
            cnt   <= 7'd1;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_ROUND: begin
          if (cnt == 7'd64) begin
            state <= S_ADD;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_ADD: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd8) begin
            case (post)
              P_IDLE: state <= S_IDLE;
              P_PAD: begin
                state    <= S_PAD;
                pad_addr <= pos[5:2];
                pad2     <= 1'b0;
              end
              P_PAD2: begin
                state    <= S_PAD;
                pad_addr <= '0;
                pad2     <= 1'b1;
              end
              default: begin
                state <= S_ORD;
                oidx  <= '0;
              end
            endcase
          end
        end
        S_ORD: begin
          state <= S_OWT;
        end
        S_OWT: begin
          if (out_load) begin
            if (oidx == 3'd7) begin
              state <= S_IDLE;
              count <= '0;
              post  <= P_IDLE;
            end else begin
              oidx  <= oidx + 3'd1;
              state <= S_ORD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // byte assembly, the last three bytes of the current word
  always_ff @(posedge clk) begin
    if (in_acc && has_byte) begin
      acc <= {acc[15:0], msg_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      digest_word <= c_rd;
      word_index  <= oidx;
      digest_done <= (oidx == 3'd7);
    end
  end

  sha_blk_mem u_blk_mem (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .re    (blk_re),
    .raddr (blk_raddr),
    .rdata (blk_rd)
  );

  sha_chain_mem u_chain_mem (
    .clk   (clk),
    .rst   (rst),
    .clr   (fin),
    .we    (c_we),
    .waddr (cnt_dec[2:0]),
    .wdata (c_rd + a_cur),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rd)
  );

  sha_round u_round (
    .clk      (clk),
    .ctl      (rctl),
    .chain_rd (c_rd),
    .blk_rd   (blk_rd),
    .a_out    (a_cur)
  );

`ifndef SYNTH
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> ((cnt >= 7'd1) && (cnt <= 7'd64)))
    else $error("round counter out of range");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digest_done == (word_index == 3'd7)))
    else $error("digest_done not on the last word");

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    fin |=> ((count == '0) && (state == S_IDLE)))
    else $error("message state not cleared after digest");
`endif

endmodule

`default_nettype wire
